/* rtl/imd_pkg.sv */
// shared types and constants for the integer matrix determinant block
`timescale 1ns / 1ps
`default_nettype none

package imd_pkg;

    // width of the determinant result and of every stored minor
    localparam int DET_BITS = 50;

    // width of the matrix size register
    localparam int SIZE_BITS = 3;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic elem_wr;     // store the transferred element
        logic acc_clear;   // zero the accumulator
        logic term_valid;  // issued column belongs to the current minor
        logic term_sign;   // subtract this term
        logic minor_wr;    // save the accumulator as the current minor
        logic out_load;    // move the accumulator into the output register
    } t_dp_cmd;

endpackage

`default_nettype wire

/* rtl/imd_datapath.sv */
// datapath: element store, minor store, shared multiplier and accumulator
`timescale 1ns / 1ps
`default_nettype none

module imd_datapath import imd_pkg::*; #(
    parameter int MAX_ORDER    = 4,
    parameter int ELEMENT_BITS = 12
) (
    input  wire                                            i_clk,
    input  wire                                            i_rst_n,
    input  t_dp_cmd                                        i_cmd,
    input  wire [((MAX_ORDER*MAX_ORDER > 1) ? $clog2(MAX_ORDER*MAX_ORDER) : 1)-1:0] i_elem_wr_addr,
    input  wire [((MAX_ORDER*MAX_ORDER > 1) ? $clog2(MAX_ORDER*MAX_ORDER) : 1)-1:0] i_elem_rd_addr,
    input  wire signed [ELEMENT_BITS-1:0]                  i_element_value,
    input  wire [MAX_ORDER-1:0]                            i_minor_rd_addr,
    input  wire [MAX_ORDER-1:0]                            i_minor_wr_addr,
    output logic signed [DET_BITS-1:0]                     o_determinant
);

    localparam int STORE_DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int MINOR_DEPTH = 1 << MAX_ORDER;

    logic signed [ELEMENT_BITS-1:0] r_elem_mem [STORE_DEPTH];
    logic signed [DET_BITS-1:0]     r_minor_mem [MINOR_DEPTH];

    // read stage
    logic signed [ELEMENT_BITS-1:0] r_elem_rd;
    logic signed [DET_BITS-1:0]     r_minor_rd;
    logic                           r_s1_valid;
    logic                           r_s1_sign;
    logic                           r_s1_base;

    // multiply stage
    logic signed [DET_BITS-1:0]     r_prod;
    logic                           r_s2_valid;
    logic                           r_s2_sign;

    logic signed [DET_BITS-1:0]     r_acc;
    logic signed [DET_BITS-1:0]     r_out;

    logic signed [DET_BITS-1:0]              w_minor_op;
    logic signed [ELEMENT_BITS+DET_BITS-1:0] w_prod_full;

    // element store: written on input transfers, read during expansion
    always_ff @(posedge i_clk) begin
        if (i_cmd.elem_wr) begin
            r_elem_mem[i_elem_wr_addr] <= i_element_value;
        end
        r_elem_rd <= r_elem_mem[i_elem_rd_addr];
    end

    // minor store indexed by the column set of the minor
    always_ff @(posedge i_clk) begin
        if (i_cmd.minor_wr) begin
            r_minor_mem[i_minor_wr_addr] <= r_acc;
        end
        r_minor_rd <= r_minor_mem[i_minor_rd_addr];
        r_s1_sign  <= i_cmd.term_sign;
        r_s1_base  <= (i_minor_rd_addr == '0);
    end

    // the empty minor has determinant one
    assign w_minor_op  = r_s1_base ? DET_BITS'(1) : r_minor_rd;
    assign w_prod_full = r_elem_rd * w_minor_op;

    always_ff @(posedge i_clk) begin
        r_prod    <= w_prod_full[DET_BITS-1:0];
        r_s2_sign <= r_s1_sign;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.term_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clear) begin
            r_acc <= '0;
        end else if (r_s2_valid) begin
            if (r_s2_sign) begin
                r_acc <= r_acc - r_prod;
            end else begin
                r_acc <= r_acc + r_prod;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= r_acc;
        end
    end

    assign o_determinant = r_out;

endmodule

`default_nettype wire

/* rtl/imd_ctrl.sv */
// sequencer: load counter, size register and expansion control
`timescale 1ns / 1ps
`default_nettype none

module imd_ctrl import imd_pkg::*; #(
    parameter int MAX_ORDER = 4
) (
    input  wire                                            i_clk,
    input  wire                                            i_rst_n,
    input  wire                                            i_cfg_wr_en,
    input  wire [SIZE_BITS-1:0]                            i_cfg_wr_data,
    input  wire                                            i_in_valid,
    output logic                                           o_in_stall,
    output logic                                           o_out_valid,
    input  wire                                            i_out_stall,
    output t_dp_cmd                                        o_cmd,
    output logic [((MAX_ORDER*MAX_ORDER > 1) ? $clog2(MAX_ORDER*MAX_ORDER) : 1)-1:0] o_elem_wr_addr,
    output logic [((MAX_ORDER*MAX_ORDER > 1) ? $clog2(MAX_ORDER*MAX_ORDER) : 1)-1:0] o_elem_rd_addr,
    output logic [MAX_ORDER-1:0]                           o_minor_rd_addr,
    output logic [MAX_ORDER-1:0]                           o_minor_wr_addr
);

    localparam int STORE_DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int ORD_W       = $clog2(MAX_ORDER + 1);
    localparam int COL_W       = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_ISSUE  = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]           r_state, n_state;
    logic [SIZE_BITS-1:0] r_size;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [MAX_ORDER-1:0] r_mask, n_mask;
    logic [COL_W-1:0]     r_col, n_col;
    logic                 r_drain, n_drain;
    logic                 r_out_valid, n_out_valid;

    logic [ORD_W-1:0]     w_order;
    logic [ORD_W-1:0]     w_pop;
    logic [ORD_W-1:0]     w_low_pop;
    logic [ORD_W-1:0]     w_row;
    logic [MAX_ORDER-1:0] w_full;
    logic [CNT_W-1:0]     w_total;
    logic [CNT_W-1:0]     w_count_inc;
    logic                 w_in_xfer;
    logic                 w_col_last;
    logic                 w_mask_last;
    logic                 w_out_free;
    t_dp_cmd              w_cmd;

    // order in force, clamped into 1..MAX_ORDER
    always_comb begin
        if (r_size == '0) begin
            w_order = ORD_W'(1);
        end else if (int'(r_size) > MAX_ORDER) begin
            w_order = ORD_W'(MAX_ORDER);
        end else begin
            w_order = ORD_W'(r_size);
        end
    end

    // set size, set bits below the column, full column set
    always_comb begin
        w_pop     = '0;
        w_low_pop = '0;
        for (int i = 0; i < MAX_ORDER; i++) begin
            w_pop = w_pop + ORD_W'(r_mask[i]);
            if (i < int'(r_col)) begin
                w_low_pop = w_low_pop + ORD_W'(r_mask[i]);
            end
            w_full[i] = (i < int'(w_order));
        end
    end

    assign w_row       = w_order - w_pop;
    assign w_total     = CNT_W'(int'(w_order) * int'(w_order));
    assign w_count_inc = r_count + CNT_W'(1);
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_col_last  = (int'(r_col) == int'(w_order) - 1);
    assign w_mask_last = (r_mask == w_full);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign o_elem_wr_addr  = r_count[ADDR_W-1:0];
    assign o_elem_rd_addr  = ADDR_W'(int'(w_row) * int'(w_order) + int'(r_col));
    assign o_minor_rd_addr = r_mask & ~(MAX_ORDER'(1) << r_col);
    assign o_minor_wr_addr = r_mask;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_mask      = r_mask;
        n_col       = r_col;
        n_drain     = r_drain;
        n_out_valid = r_out_valid;
        w_cmd       = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_LOAD: begin
                if (w_in_xfer) begin
                    w_cmd.elem_wr = 1'b1;
                    if (w_count_inc >= w_total) begin
                        n_count       = '0;
                        n_mask        = MAX_ORDER'(1);
                        n_col         = '0;
                        w_cmd.acc_clear = 1'b1;
                        n_state       = S_ISSUE;
                    end else begin
                        n_count = w_count_inc;
                    end
                end
            end
            S_ISSUE: begin
                w_cmd.term_valid = r_mask[r_col];
                w_cmd.term_sign  = w_low_pop[0];
                if (w_col_last) begin
                    n_drain = 1'b0;
                    n_state = S_DRAIN;
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end
            S_DRAIN: begin
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = w_mask_last ? S_FINISH : S_WRITE;
                end
            end
            S_WRITE: begin
                w_cmd.minor_wr  = 1'b1;
                w_cmd.acc_clear = 1'b1;
                n_mask          = r_mask + MAX_ORDER'(1);
                n_col           = '0;
                n_state         = S_ISSUE;
            end
            S_FINISH: begin
                if (w_out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_size      <= SIZE_BITS'(4);
            r_count     <= '0;
            r_mask      <= '0;
            r_col       <= '0;
            r_drain     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_mask      <= n_mask;
            r_col       <= n_col;
            r_drain     <= n_drain;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_size <= i_cfg_wr_data;
            end
        end
    end

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

`default_nettype wire

/* rtl/integer_matrix_determinant.sv */
// top level of the integer matrix determinant block
`timescale 1ns / 1ps
`default_nettype none

// channel   | valid       | stall        | payload
// ----------+-------------+--------------+-------------------------------------
// input     | i_in_valid  | o_in_stall   | i_element_value (row-major element)
// output    | o_out_valid | i_out_stall  | o_determinant (exact determinant)
// config    | i_cfg_wr_en | -            | i_cfg_wr_data (matrix order)
//
// loading accepts one element transfer per cycle, no gap between elements
// after the last element of an order-n matrix the expansion makes
// one pass per column subset through the single shared multiplier,
// with n issue slots plus drain and write-back
// input stalls from the last element until the result enters the output register
// a result waiting on i_out_stall does not block loading of the next matrix
// reset sets the order to 4 and empties the load counter and output; stores keep contents

module integer_matrix_determinant import imd_pkg::*; #(
    parameter int MAX_ORDER    = 4,
    parameter int ELEMENT_BITS = 12
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // configuration write
    input  wire                           i_cfg_wr_en,
    input  wire [SIZE_BITS-1:0]           i_cfg_wr_data,
    // element input
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  wire signed [ELEMENT_BITS-1:0] i_element_value,
    // determinant output
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output logic signed [DET_BITS-1:0]    o_determinant
);

    localparam int STORE_DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    t_dp_cmd              w_cmd;
    logic [ADDR_W-1:0]    w_elem_wr_addr;
    logic [ADDR_W-1:0]    w_elem_rd_addr;
    logic [MAX_ORDER-1:0] w_minor_rd_addr;
    logic [MAX_ORDER-1:0] w_minor_wr_addr;

    // sequencer: walks column subsets in increasing order so every
    // smaller minor is already stored when a larger one needs it
    imd_ctrl #(
        .MAX_ORDER (MAX_ORDER)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_cmd           (w_cmd),
        .o_elem_wr_addr  (w_elem_wr_addr),
        .o_elem_rd_addr  (w_elem_rd_addr),
        .o_minor_rd_addr (w_minor_rd_addr),
        .o_minor_wr_addr (w_minor_wr_addr)
    );

    // datapath: each term is element times stored minor, summed with
    // alternating sign into the minor of the next larger column set
    imd_datapath #(
        .MAX_ORDER    (MAX_ORDER),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_elem_wr_addr  (w_elem_wr_addr),
        .i_elem_rd_addr  (w_elem_rd_addr),
        .i_element_value (i_element_value),
        .i_minor_rd_addr (w_minor_rd_addr),
        .i_minor_wr_addr (w_minor_wr_addr),
        .o_determinant   (o_determinant)
    );

endmodule

`default_nettype wire
